### rtl/isobmff_image_box_walker_unit_assert.svh
// assertion macros for the image box walker
// expects clk and rst_n in the scope where a macro is used
`ifndef ISOBMFF_IMAGE_BOX_WALKER_UNIT_ASSERT_SVH
`define ISOBMFF_IMAGE_BOX_WALKER_UNIT_ASSERT_SVH

// same-cycle implication
`define IBW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibw assertion failed");

// next-cycle implication
`define IBW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibw assertion failed");

`endif

### rtl/ibw_pkg.sv
// shared types and constants of the image box walker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ibw_pkg;

    localparam int OUT_LEN_BITS = 40;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_FTYP = 2'd1,
        PH_SKIP = 2'd2,
        PH_HDR  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CFG_ACCEPT_AVIF     = 2'd0,
        CFG_ACCEPT_HEIF     = 2'd1,
        CFG_MIN_HEADER_SIZE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic       accept_avif;
        logic       accept_heif;
        logic [7:0] min_header_size;
    } cfg_t;

    typedef struct packed {
        logic                    is_match;
        logic                    brand_kind;
        logic [OUT_LEN_BITS-1:0] total_length;
    } result_t;

    // box type and brand codes, big-endian ascii
    localparam logic [31:0] TYPE_FTYP = 32'h6674_7970;
    localparam logic [31:0] TYPE_AVIF = 32'h6176_6966;
    localparam logic [31:0] TYPE_HEIC = 32'h6865_6963;
    localparam logic [31:0] TYPE_META = 32'h6d65_7461;
    localparam logic [31:0] TYPE_MDAT = 32'h6d64_6174;
    localparam logic [31:0] TYPE_MOOV = 32'h6d6f_6f76;

    localparam logic [31:0] BOX_HDR_BYTES  = 32'd8;
    localparam logic [31:0] FTYP_HDR_BYTES = 32'd12;
    localparam logic [7:0]  FTYP_MIN_SIZE  = 8'd12;

    // header byte counts at which a field is complete
    localparam logic [3:0] CNT_SIZE  = 4'd4;
    localparam logic [3:0] CNT_TYPE  = 4'd8;
    localparam logic [3:0] CNT_BRAND = 4'd12;

    localparam int SEEN_META = 0;
    localparam int SEEN_MOOV = 1;
    localparam int SEEN_MDAT = 2;

endpackage

`default_nettype wire

### rtl/ibw_cfg.sv
// configuration registers of the image box walker
// depends on ibw_pkg
`timescale 1ns / 1ps
`default_nettype none

module ibw_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output ibw_pkg::cfg_t    cfg
);

    ibw_pkg::cfg_t cfg_reg;
    ibw_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                ibw_pkg::CFG_ACCEPT_AVIF:     cfg_next.accept_avif = cfg_data[0];
                ibw_pkg::CFG_ACCEPT_HEIF:     cfg_next.accept_heif = cfg_data[0];
                ibw_pkg::CFG_MIN_HEADER_SIZE: cfg_next.min_header_size = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accept_avif     <= 1'b1;
            cfg_reg.accept_heif     <= 1'b1;
            cfg_reg.min_header_size <= ibw_pkg::FTYP_MIN_SIZE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/ibw_walker.sv
// box walk state and per-byte next-state logic
// depends on ibw_pkg
`timescale 1ns / 1ps
`default_nettype none

module ibw_walker #(
    parameter int LENGTH_BITS = 40
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   data_byte,
    input  wire logic         first_byte,
    input  wire logic         last_byte,
    input  ibw_pkg::cfg_t     cfg,
    output logic              fire,
    output ibw_pkg::result_t  result,
    output ibw_pkg::phase_t   phase
);

    ibw_pkg::phase_t          phase_reg, phase_next, cur_phase;
    logic [3:0]               cnt_reg, cnt_next, cur_cnt, cnt_inc;
    logic [31:0]              shift_reg, shift_next, cur_shift, hdr_word;
    logic [31:0]              box_reg, box_next, cur_box;
    logic [31:0]              skip_reg, skip_next, cur_skip;
    logic [LENGTH_BITS-1:0]   run_reg, run_next, cur_run;
    logic [2:0]               seen_reg, seen_next, cur_seen;
    logic                     brand_reg, brand_next, cur_brand;
    logic [7:0]               min_size;
    logic                     walked;
    logic                     ok;

    // a first byte restarts the walk before the byte is processed
    assign cur_phase = first_byte ? ibw_pkg::PH_FTYP : phase_reg;
    assign cur_cnt   = first_byte ? 4'd0 : cnt_reg;
    assign cur_shift = first_byte ? 32'd0 : shift_reg;
    assign cur_box   = first_byte ? 32'd0 : box_reg;
    assign cur_skip  = first_byte ? 32'd0 : skip_reg;
    assign cur_run   = first_byte ? '0 : run_reg;
    assign cur_seen  = first_byte ? 3'd0 : seen_reg;
    assign cur_brand = first_byte ? 1'b0 : brand_reg;

    assign hdr_word = {cur_shift[23:0], data_byte};
    assign cnt_inc  = cur_cnt + 4'd1;
    assign min_size = (cfg.min_header_size < ibw_pkg::FTYP_MIN_SIZE)
                      ? ibw_pkg::FTYP_MIN_SIZE : cfg.min_header_size;

    always_comb
    begin
        phase_next = cur_phase;
        cnt_next   = cur_cnt;
        shift_next = cur_shift;
        box_next   = cur_box;
        skip_next  = cur_skip;
        run_next   = cur_run;
        seen_next  = cur_seen;
        brand_next = cur_brand;
        fire       = 1'b0;
        walked     = 1'b0;

        case (cur_phase)
            ibw_pkg::PH_FTYP:
            begin
                shift_next = hdr_word;
                cnt_next   = cnt_inc;
                if (cnt_inc == ibw_pkg::CNT_SIZE)
                begin
                    box_next = hdr_word;
                end
                else if (cnt_inc == ibw_pkg::CNT_TYPE)
                begin
                    if (cur_box < 32'(min_size) || hdr_word != ibw_pkg::TYPE_FTYP)
                    begin
                        fire = 1'b1;
                    end
                end
                else if (cnt_inc == ibw_pkg::CNT_BRAND)
                begin
                    if (cfg.accept_avif && hdr_word == ibw_pkg::TYPE_AVIF)
                    begin
                        brand_next = 1'b0;
                    end
                    else if (cfg.accept_heif && hdr_word == ibw_pkg::TYPE_HEIC)
                    begin
                        brand_next = 1'b1;
                    end
                    else
                    begin
                        fire = 1'b1;
                    end
                    if (!fire)
                    begin
                        run_next   = LENGTH_BITS'(cur_box);
                        skip_next  = cur_box - ibw_pkg::FTYP_HDR_BYTES;
                        cnt_next   = 4'd0;
                        shift_next = 32'd0;
                        phase_next = (skip_next == 32'd0) ? ibw_pkg::PH_HDR
                                                          : ibw_pkg::PH_SKIP;
                    end
                end
            end
            ibw_pkg::PH_SKIP:
            begin
                skip_next = cur_skip - 32'd1;
                if (skip_next == 32'd0)
                begin
                    phase_next = ibw_pkg::PH_HDR;
                    cnt_next   = 4'd0;
                    shift_next = 32'd0;
                end
            end
            ibw_pkg::PH_HDR:
            begin
                shift_next = hdr_word;
                cnt_next   = cnt_inc;
                if (cnt_inc == ibw_pkg::CNT_SIZE)
                begin
                    box_next = hdr_word;
                    // too small, or would carry the length past its width
                    if (hdr_word < ibw_pkg::BOX_HDR_BYTES
                        || LENGTH_BITS'(hdr_word) > ~cur_run)
                    begin
                        fire   = 1'b1;
                        walked = 1'b1;
                    end
                end
                else if (cnt_inc == ibw_pkg::CNT_TYPE)
                begin
                    if (hdr_word == ibw_pkg::TYPE_META)
                    begin
                        seen_next[ibw_pkg::SEEN_META] = 1'b1;
                    end
                    else if (hdr_word == ibw_pkg::TYPE_MDAT)
                    begin
                        seen_next[ibw_pkg::SEEN_MDAT] = 1'b1;
                    end
                    else if (hdr_word == ibw_pkg::TYPE_MOOV)
                    begin
                        seen_next[ibw_pkg::SEEN_MOOV] = 1'b1;
                    end
                    else
                    begin
                        fire   = 1'b1;
                        walked = 1'b1;
                    end
                    if (!fire)
                    begin
                        run_next   = cur_run + LENGTH_BITS'(cur_box);
                        skip_next  = cur_box - ibw_pkg::BOX_HDR_BYTES;
                        cnt_next   = 4'd0;
                        shift_next = 32'd0;
                        phase_next = (skip_next == 32'd0) ? ibw_pkg::PH_HDR
                                                          : ibw_pkg::PH_SKIP;
                    end
                end
            end
            default:
            begin
                phase_next = cur_phase;
            end
        endcase

        // end of input closes the walk as if a bad header had come
        if (cur_phase != ibw_pkg::PH_IDLE && last_byte && !fire)
        begin
            fire   = 1'b1;
            walked = (phase_next != ibw_pkg::PH_FTYP);
        end

        if (fire)
        begin
            phase_next = ibw_pkg::PH_IDLE;
        end
    end

    assign ok = walked && (seen_next[ibw_pkg::SEEN_MOOV] || seen_next[ibw_pkg::SEEN_MDAT]);

    always_comb
    begin
        result.is_match     = ok;
        result.brand_kind   = ok && brand_next;
        result.total_length = ok ? ibw_pkg::OUT_LEN_BITS'(run_next) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ibw_pkg::PH_IDLE;
            cnt_reg   <= 4'd0;
            shift_reg <= 32'd0;
            box_reg   <= 32'd0;
            skip_reg  <= 32'd0;
            run_reg   <= '0;
            seen_reg  <= 3'd0;
            brand_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            box_reg   <= box_next;
            skip_reg  <= skip_next;
            run_reg   <= run_next;
            seen_reg  <= seen_next;
            brand_reg <= brand_next;
        end
    end

    assign phase = phase_reg;

endmodule

`default_nettype wire

### rtl/ibw_out_reg.sv
// result register with valid/stall handshake
// depends on ibw_pkg
`timescale 1ns / 1ps
`default_nettype none

module ibw_out_reg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  ibw_pkg::result_t  result,
    output logic              busy,
    output logic              out_valid,
    input  wire logic         out_stall,
    output ibw_pkg::result_t  out_result
);

    logic              valid_reg, valid_next;
    ibw_pkg::result_t  data_reg;

    // register is free when empty or being taken this cycle
    assign busy = valid_reg && out_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = data_reg;

endmodule

`default_nettype wire

### rtl/isobmff_image_box_walker_unit.sv
// channel   | signals                                   | dir
// ----------+-------------------------------------------+-----
// input     | in_valid, in_stall, data_byte, first_byte,| in
//           | last_byte                                 |
// result    | out_valid, out_stall, is_match,           | out
//           | brand_kind, total_length                  |
// config    | cfg_write, cfg_index, cfg_data            | in
//
// one byte per cycle while in_stall is low; each byte updates the walk state in the cycle it is taken
// a result is loaded into the output register when its deciding byte is taken
// in_stall rises only while a result sits in the output register and out_stall is high
// reset leaves the walker idle: bytes are ignored until one marked first_byte
// top level of the image box walker; depends on ibw_pkg, ibw_cfg, ibw_walker, ibw_out_reg
`timescale 1ns / 1ps
`default_nettype none

`include "isobmff_image_box_walker_unit_assert.svh"

module isobmff_image_box_walker_unit #(
    parameter int LENGTH_BITS = 40
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             is_match,
    output logic             brand_kind,
    output logic [39:0]      total_length
);

    ibw_pkg::cfg_t     cfg;
    ibw_pkg::result_t  walk_result;
    ibw_pkg::result_t  out_result;
    ibw_pkg::phase_t   walk_phase;
    logic              in_accept;
    logic              fire;

    assign in_accept = in_valid && !in_stall;

    ibw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ibw_walker #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .cfg        (cfg),
        .fire       (fire),
        .result     (walk_result),
        .phase      (walk_phase)
    );

    ibw_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_accept && fire),
        .result     (walk_result),
        .busy       (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign is_match     = out_result.is_match;
    assign brand_kind   = out_result.brand_kind;
    assign total_length = out_result.total_length;

    `IBW_ASSERT_IMP(a_nomatch_zero, out_valid && !is_match, brand_kind == 1'b0 && total_length == 40'd0)
    `IBW_ASSERT_IMP(a_stall_needs_result, in_stall, out_valid)
    `IBW_ASSERT_NXT(a_start_no_result, in_accept && first_byte && !last_byte, !out_valid && walk_phase == ibw_pkg::PH_FTYP)

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the image box walker: streams candidate files byte by byte
// and checks every result against a walk predictor kept inside the bench
// depends on ibw_pkg and isobmff_image_box_walker_unit
`timescale 1ns / 1ps

module tb_top;

    localparam int LENGTH_BITS = 40;
    localparam longint unsigned LEN_MAX = (64'd1 << LENGTH_BITS) - 64'd1;
    localparam int LIMIT = 1_000_000;
    localparam int LONG_HOLD = 300;
    // a box type the walker does not know
    localparam logic [31:0] TYPE_FREE = 32'h6672_6565;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = ibw_pkg::CFG_ACCEPT_AVIF;
    logic [7:0]  cfg_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        first_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        is_match;
    logic        brand_kind;
    logic [39:0] total_length;

    isobmff_image_box_walker_unit #(
        .LENGTH_BITS(LENGTH_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .first_byte(first_byte),
        .last_byte(last_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .is_match(is_match),
        .brand_kind(brand_kind),
        .total_length(total_length)
    );

    // register copies
    logic       p_accept_avif = 1'b1;
    logic       p_accept_heif = 1'b1;
    logic [7:0] p_min_size = 8'd12;

    // walk state of the predictor
    ibw_pkg::phase_t w_phase = ibw_pkg::PH_IDLE;
    logic [3:0]  w_count = '0;
    logic [31:0] w_shift = '0;
    logic [31:0] w_box_size = '0;
    logic [31:0] w_skip = '0;
    logic [63:0] w_length = '0;
    logic [2:0]  w_seen = '0;
    logic        w_brand = 1'b0;
    logic        w_decided = 1'b1;

    ibw_pkg::result_t pending_results[$];
    ibw_pkg::result_t oldest;
    logic [7:0]  stream_q[$];
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned gap_max = 16;
    int unsigned stall_max = 16;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic ibw_pkg::result_t close_walk(input logic walked);
        ibw_pkg::result_t r;
        logic    ok;
        ok = walked && (w_seen[ibw_pkg::SEEN_MOOV] || w_seen[ibw_pkg::SEEN_MDAT]);
        r.is_match = ok;
        r.brand_kind = ok ? w_brand : 1'b0;
        r.total_length = ok ? w_length[ibw_pkg::OUT_LEN_BITS-1:0] : '0;
        w_decided = 1'b1;
        w_phase = ibw_pkg::PH_IDLE;
        return r;
    endfunction

    function automatic void open_box(input logic [31:0] consumed);
        w_skip = w_box_size - consumed;
        w_count = '0;
        w_shift = '0;
        if (w_skip == 0)
            w_phase = ibw_pkg::PH_HDR;
        else
            w_phase = ibw_pkg::PH_SKIP;
    endfunction

    // advances the walk by one byte; returns 1 when the byte decides the outcome
    function automatic logic walk_byte(input logic [7:0] b, input logic first,
                                       input logic last, output ibw_pkg::result_t res);
        logic [7:0] min_eff;
        res = '0;
        if (first) begin
            w_phase = ibw_pkg::PH_FTYP;
            w_count = '0;
            w_shift = '0;
            w_box_size = '0;
            w_skip = '0;
            w_length = '0;
            w_seen = '0;
            w_brand = 1'b0;
            w_decided = 1'b0;
        end
        if (w_decided)
            return 1'b0;
        case (w_phase)
            ibw_pkg::PH_FTYP:
            begin
                w_shift = {w_shift[23:0], b};
                w_count++;
                if (w_count == ibw_pkg::CNT_SIZE) begin
                    w_box_size = w_shift;
                end else if (w_count == ibw_pkg::CNT_TYPE) begin
                    min_eff = (p_min_size < ibw_pkg::FTYP_MIN_SIZE)
                              ? ibw_pkg::FTYP_MIN_SIZE : p_min_size;
                    if (w_box_size < min_eff || w_shift != ibw_pkg::TYPE_FTYP) begin
                        res = close_walk(1'b0);
                        return 1'b1;
                    end
                end else if (w_count == ibw_pkg::CNT_BRAND) begin
                    // avif wins when both brands are enabled
                    if (p_accept_avif && w_shift == ibw_pkg::TYPE_AVIF) begin
                        w_brand = 1'b0;
                    end else if (p_accept_heif && w_shift == ibw_pkg::TYPE_HEIC) begin
                        w_brand = 1'b1;
                    end else begin
                        res = close_walk(1'b0);
                        return 1'b1;
                    end
                    w_length = {32'd0, w_box_size};
                    open_box(ibw_pkg::FTYP_HDR_BYTES);
                end
            end
            ibw_pkg::PH_SKIP:
            begin
                w_skip--;
                if (w_skip == 0) begin
                    w_phase = ibw_pkg::PH_HDR;
                    w_count = '0;
                    w_shift = '0;
                end
            end
            ibw_pkg::PH_HDR:
            begin
                w_shift = {w_shift[23:0], b};
                w_count++;
                if (w_count == ibw_pkg::CNT_SIZE) begin
                    w_box_size = w_shift;
                    if (w_box_size < ibw_pkg::BOX_HDR_BYTES
                        || {32'd0, w_box_size} > LEN_MAX - w_length)
                    begin
                        res = close_walk(1'b1);
                        return 1'b1;
                    end
                end else if (w_count == ibw_pkg::CNT_TYPE) begin
                    if (w_shift == ibw_pkg::TYPE_META) begin
                        w_seen[ibw_pkg::SEEN_META] = 1'b1;
                    end else if (w_shift == ibw_pkg::TYPE_MDAT) begin
                        w_seen[ibw_pkg::SEEN_MDAT] = 1'b1;
                    end else if (w_shift == ibw_pkg::TYPE_MOOV) begin
                        w_seen[ibw_pkg::SEEN_MOOV] = 1'b1;
                    end else begin
                        res = close_walk(1'b1);
                        return 1'b1;
                    end
                    w_length = w_length + {32'd0, w_box_size};
                    open_box(ibw_pkg::BOX_HDR_BYTES);
                end
            end
            default:
            begin
            end
        endcase
        // running out of input counts as a terminating header
        if (last) begin
            res = close_walk(w_phase != ibw_pkg::PH_FTYP);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void push_word(input logic [31:0] w);
        stream_q.push_back(w[31:24]);
        stream_q.push_back(w[23:16]);
        stream_q.push_back(w[15:8]);
        stream_q.push_back(w[7:0]);
    endfunction

    function automatic void start_ftyp(input logic [31:0] size, input logic [31:0] kind,
                                       input logic [31:0] brand);
        stream_q.delete();
        push_word(size);
        push_word(kind);
        push_word(brand);
    endfunction

    // mostly well-formed files with small boxes, now and then a broken or cut one
    function automatic void build_file();
        int unsigned min_eff;
        int unsigned fsize;
        int unsigned bsize;
        int unsigned pick;
        int unsigned cut;
        logic [31:0] btype;
        min_eff = (p_min_size < ibw_pkg::FTYP_MIN_SIZE) ? ibw_pkg::FTYP_MIN_SIZE : p_min_size;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            fsize = $urandom_range(0, min_eff - 1);
        else if (pick == 1)
            fsize = $urandom;
        else
            fsize = min_eff + $urandom_range(0, 6);
        pick = $urandom_range(0, 9);
        if (pick < 5)
            btype = ibw_pkg::TYPE_AVIF;
        else if (pick < 9)
            btype = ibw_pkg::TYPE_HEIC;
        else
            btype = $urandom;
        start_ftyp(fsize, ($urandom_range(0, 15) == 0) ? $urandom : ibw_pkg::TYPE_FTYP, btype);
        if (fsize > 300) begin
            repeat ($urandom_range(0, 6)) stream_q.push_back(rand_byte());
            return;
        end
        if (fsize > 12)
            repeat (fsize - 12) stream_q.push_back(rand_byte());
        repeat ($urandom_range(0, 4)) begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                bsize = $urandom_range(0, 7);
            else if (pick == 1)
                bsize = $urandom;
            else
                bsize = $urandom_range(8, 24);
            pick = $urandom_range(0, 12);
            if (pick < 4)
                btype = ibw_pkg::TYPE_META;
            else if (pick < 8)
                btype = ibw_pkg::TYPE_MDAT;
            else if (pick < 12)
                btype = ibw_pkg::TYPE_MOOV;
            else
                btype = ($urandom_range(0, 1) == 0) ? TYPE_FREE : $urandom;
            push_word(bsize);
            push_word(btype);
            if (bsize > 300) begin
                repeat ($urandom_range(0, 6)) stream_q.push_back(rand_byte());
                return;
            end
            if (bsize > 8)
                repeat (bsize - 8) stream_q.push_back(rand_byte());
        end
        if ($urandom_range(0, 9) == 0)
            stream_q[$urandom_range(0, stream_q.size() - 1)] = rand_byte();
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, stream_q.size());
            while (stream_q.size() > cut)
                void'(stream_q.pop_back());
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        int unsigned gap;
        ibw_pkg::result_t r;
        gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        first_byte <= first;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (walk_byte(b, first, last, r))
            pending_results.push_back(r);
    endtask

    task automatic send_file(input logic close_it);
        for (int i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], i == 0, close_it && i == stream_q.size() - 1);
        bytes_sent += stream_q.size();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // writes all three registers back to back while the walker is idle
    task automatic apply_settings(input logic avif, input logic heif,
                                  input logic [7:0] min_size);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= ibw_pkg::CFG_ACCEPT_AVIF;
        cfg_data <= {7'($urandom_range(0, 127)), avif};
        @(posedge clk);
        cfg_index <= ibw_pkg::CFG_ACCEPT_HEIF;
        cfg_data <= {7'($urandom_range(0, 127)), heif};
        @(posedge clk);
        cfg_index <= ibw_pkg::CFG_MIN_HEADER_SIZE;
        cfg_data <= min_size;
        @(posedge clk);
        cfg_write <= 1'b0;
        p_accept_avif = avif;
        p_accept_heif = heif;
        p_min_size = min_size;
    endtask

    task automatic test_ignored_bytes();
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(rand_byte(), 1'b0, 1'b0);
        // a file of one byte
        send_byte(8'ha5, 1'b1, 1'b1);
    endtask

    task automatic test_matching_files();
        start_ftyp(32'd12, ibw_pkg::TYPE_FTYP, ibw_pkg::TYPE_AVIF);
        push_word(32'd8);
        push_word(ibw_pkg::TYPE_MDAT);
        send_file(1'b1);
        // bytes after the decision stay silent
        send_byte(8'h00, 1'b0, 1'b1);
        // ftyp with two bytes of padding, then meta with one body byte, then moov
        start_ftyp(32'd14, ibw_pkg::TYPE_FTYP, ibw_pkg::TYPE_HEIC);
        stream_q.push_back(8'hff);
        stream_q.push_back(8'hff);
        push_word(32'd9);
        push_word(ibw_pkg::TYPE_META);
        stream_q.push_back(8'hff);
        push_word(32'd8);
        push_word(ibw_pkg::TYPE_MOOV);
        send_file(1'b1);
    endtask

    task automatic test_walk_ends();
        // box size below 8 after a moov
        start_ftyp(32'd12, ibw_pkg::TYPE_FTYP, ibw_pkg::TYPE_AVIF);
        push_word(32'd8);
        push_word(ibw_pkg::TYPE_MOOV);
        push_word(32'd7);
        push_word(ibw_pkg::TYPE_MDAT);
        send_file(1'b1);
        // unknown type with only meta seen
        start_ftyp(32'd12, ibw_pkg::TYPE_FTYP, ibw_pkg::TYPE_HEIC);
        push_word(32'd8);
        push_word(ibw_pkg::TYPE_META);
        push_word(32'd8);
        push_word(TYPE_FREE);
        send_file(1'b1);
        // huge mdat cut short by the end of input
        start_ftyp(32'd12, ibw_pkg::TYPE_FTYP, ibw_pkg::TYPE_AVIF);
        push_word(32'hffff_ffff);
        push_word(ibw_pkg::TYPE_MDAT);
        push_word(32'h0000_00ff);
        send_file(1'b1);
        // ftyp rejects: short size, wrong type, unknown brand
        start_ftyp(32'd11, ibw_pkg::TYPE_FTYP, ibw_pkg::TYPE_AVIF);
        send_file(1'b1);
        start_ftyp(32'd12, ibw_pkg::TYPE_MOOV, ibw_pkg::TYPE_AVIF);
        send_file(1'b1);
        start_ftyp(32'd12, ibw_pkg::TYPE_FTYP, ibw_pkg::TYPE_MDAT);
        send_file(1'b1);
    endtask

    task automatic test_restart();
        start_ftyp(32'd12, ibw_pkg::TYPE_FTYP, ibw_pkg::TYPE_AVIF);
        void'(stream_q.pop_back());
        send_file(1'b0);
        start_ftyp(32'd12, ibw_pkg::TYPE_FTYP, ibw_pkg::TYPE_HEIC);
        push_word(32'd16);
        push_word(ibw_pkg::TYPE_MDAT);
        push_word(32'h0102_0304);
        send_file(1'b1);
    endtask

    task automatic run_random_files(input int unsigned count);
        repeat (count) begin
            build_file();
            send_file(1'b1);
        end
    endtask

    task automatic test_register_settings();
        apply_settings(1'b0, 1'b1, 8'd0);
        run_random_files(1);
        apply_settings(1'b1, 1'b0, 8'd24);
        run_random_files(1);
        apply_settings(1'b0, 1'b0, 8'd13);
        run_random_files(1);
        apply_settings(1'b1, 1'b1, 8'd12);
    endtask

    task automatic test_output_backpressure();
        gap_max = 0;
        hold_left = LONG_HOLD;
        repeat (3) begin
            send_byte(rand_byte(), 1'b1, 1'b1);
            start_ftyp(32'd12, ibw_pkg::TYPE_FTYP, ibw_pkg::TYPE_AVIF);
            push_word(32'd8);
            push_word(ibw_pkg::TYPE_MOOV);
            send_file(1'b1);
        end
        gap_max = 16;
        drain();
    endtask

    task automatic test_random_streams();
        int unsigned first_count;
        first_count = bytes_sent;
        while (bytes_sent - first_count < 64) begin
            // stretches without idling on either side
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
            stall_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
            build_file();
            send_file($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3))
                    send_byte(rand_byte(), 1'b0, 1'($urandom_range(0, 1)));
        end
        // close any walk left open
        send_byte(rand_byte(), 1'b1, 1'b1);
        gap_max = 16;
        stall_max = 16;
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ignored_bytes();
        test_matching_files();
        test_walk_ends();
        test_restart();
        test_register_settings();
        test_output_backpressure();
        test_random_streams();
        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // result receiver: random stall per item, plus the long hold when asked
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (out_valid && stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if (out_valid && !out_stall)
                    stall_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, stall_max);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: match %0d brand %0d length %0h",
                         $time, is_match, brand_kind, total_length);
                mismatch_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (is_match !== oldest.is_match) begin
                    $display("%0t: is_match expected %0d actual %0d",
                             $time, oldest.is_match, is_match);
                    mismatch_count++;
                end
                if (brand_kind !== oldest.brand_kind) begin
                    $display("%0t: brand_kind expected %0d actual %0d",
                             $time, oldest.brand_kind, brand_kind);
                    mismatch_count++;
                end
                if (total_length !== oldest.total_length) begin
                    $display("%0t: total_length expected %0h actual %0h",
                             $time, oldest.total_length, total_length);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/ibw_pkg.sv
rtl/ibw_cfg.sv
rtl/ibw_walker.sv
rtl/ibw_out_reg.sv
rtl/isobmff_image_box_walker_unit.sv
tb/tb_top.sv
